/* rtl/lbcs_pkg.sv */
// Shared types and constants for the lane border center scan block.
`default_nettype none
package lbcs_pkg;

  localparam int unsigned PosW            = 12;
  localparam int unsigned RunW            = 4;
  localparam int unsigned WidthW          = 13;
  localparam int unsigned MaxWidthDefault = 4096;

  localparam logic [RunW-1:0]   RunMax        = 4'd15;
  localparam logic [WidthW-1:0] WidthReset    = 13'd640;
  localparam logic [RunW-1:0]   MinRunReset   = 4'd4;

  // register index, taken from paddr[2]
  localparam logic RegImageWidth = 1'b0;
  localparam logic RegMinRun     = 1'b1;

  typedef struct packed {
    logic [WidthW-1:0] image_width;
    logic [RunW-1:0]   min_run;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] row_out;
    logic            found;
    logic [PosW-1:0] center_pos;
    logic [PosW-1:0] right_pos;
    logic [PosW-1:0] left_pos;
  } result_t;

endpackage
`default_nettype wire

/* rtl/lane_border_center_scan.sv */
// Top level of the lane border center scan block.
//
// Takes one thresholded pixel per transaction in raster order and reports,
// on the last pixel of every row, the left border, the last right border,
// their floored midpoint, a found flag and the row tag. A pixel is accepted
// every clock cycle; the only limit is the single result register, which
// holds a row result until the master side takes it, and pixels keep flowing
// as long as it is empty or drained in the same cycle. A row result appears
// on the master side in the cycle after its last pixel is accepted. Row length
// and minimum run are set over APB (image_width at 0x0, min_run at 0x4) and
// should only change while the block is idle.
`default_nettype none
module lane_border_center_scan #(
  parameter int unsigned MAX_WIDTH = lbcs_pkg::MaxWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] pixel_on, [12:1] row_tag, [15:13] zero
  input  wire logic [15:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [11:0] left_pos, [23:12] right_pos, [35:24] center_pos, [36] found,
  // [48:37] row_out, [55:49] zero
  output logic      [55:0] m_axis_tdata
);

  lbcs_pkg::cfg_t    cfg;
  lbcs_pkg::result_t res;

  lbcs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lbcs_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pixel_on_i  (s_axis_tdata[0]),
    .row_tag_i   (s_axis_tdata[12:1]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (res)
  );

  assign m_axis_tdata = {7'd0, res.row_out, res.found, res.center_pos,
                         res.right_pos, res.left_pos};

endmodule
`default_nettype wire

/* rtl/lbcs_regs.sv */
// APB configuration registers for the lane border center scan block.
`default_nettype none
module lbcs_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output lbcs_pkg::cfg_t     cfg_o
);

  logic [lbcs_pkg::WidthW-1:0] width_q, width_d;
  logic [lbcs_pkg::RunW-1:0]   min_run_q, min_run_d;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    width_d   = width_q;
    min_run_d = min_run_q;
    if (wr_en) begin
      case (paddr[2])
        lbcs_pkg::RegImageWidth: width_d   = pwdata[lbcs_pkg::WidthW-1:0];
        lbcs_pkg::RegMinRun:     min_run_d = pwdata[lbcs_pkg::RunW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= lbcs_pkg::WidthReset;
      min_run_q <= lbcs_pkg::MinRunReset;
    end else begin
      width_q   <= width_d;
      min_run_q <= min_run_d;
    end
  end

  always_comb begin
    case (paddr[2])
      lbcs_pkg::RegImageWidth: prdata = {{(32-lbcs_pkg::WidthW){1'b0}}, width_q};
      lbcs_pkg::RegMinRun:     prdata = {{(32-lbcs_pkg::RunW){1'b0}}, min_run_q};
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.image_width = width_q;
  assign cfg_o.min_run     = min_run_q;

endmodule
`default_nettype wire

/* rtl/lbcs_core.sv */
// Per-pixel row scan: column and run counters, border latches, result register.
`default_nettype none
module lbcs_core #(
  parameter int unsigned MAX_WIDTH = lbcs_pkg::MaxWidthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lbcs_pkg::cfg_t        cfg_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  pixel_on_i,
  input  wire logic [lbcs_pkg::PosW-1:0] row_tag_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output lbcs_pkg::result_t          result_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = ((CW > lbcs_pkg::WidthW) ? CW : lbcs_pkg::WidthW) + 1;
  localparam logic [EW-1:0] MaxW = EW'(MAX_WIDTH);

  logic [CW-1:0]               col_q, col_d;
  logic [lbcs_pkg::RunW-1:0]   run_q, run_d;
  logic                        lf_q, lf_d;
  logic [lbcs_pkg::PosW-1:0]   left_q, left_d;
  logic [lbcs_pkg::PosW-1:0]   right_q, right_d;
  logic                        ovalid_q, ovalid_d;
  lbcs_pkg::result_t           res_q, res_d;

  logic [EW-1:0]               w_raw, w_eff, half, col_x, col_p1;
  logic [lbcs_pkg::RunW-1:0]   run_inc;
  logic                        accept, over, take_left, take_right, last;
  logic [lbcs_pkg::PosW-1:0]   left_n, right_n;
  logic [lbcs_pkg::PosW:0]     sum;

  assign in_ready_o = ~ovalid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    w_raw = EW'(cfg_i.image_width);
    if (w_raw > MaxW)       w_eff = MaxW;
    else if (w_raw == '0)   w_eff = EW'(1);
    else                    w_eff = w_raw;
  end

  assign half   = w_eff >> 1;
  assign col_x  = EW'(col_q);
  assign col_p1 = col_x + EW'(1);
  assign last   = col_p1 >= w_eff;

  always_comb begin
    if (!pixel_on_i)                    run_inc = '0;
    else if (run_q == lbcs_pkg::RunMax) run_inc = run_q;
    else                                run_inc = run_q + 1'b1;
  end

  assign over       = run_inc > cfg_i.min_run;
  assign take_left  = over & ~lf_q & (col_x < half);
  assign take_right = over & lf_q & (col_x > half);

  // borders including a hit on the current pixel
  assign left_n  = take_left ? lbcs_pkg::PosW'(col_q) : left_q;
  assign right_n = take_right ? lbcs_pkg::PosW'(col_q) : right_q;
  assign sum     = {1'b0, left_n} + {1'b0, right_n};

  always_comb begin
    col_d    = col_q;
    run_d    = run_q;
    lf_d     = lf_q;
    left_d   = left_q;
    right_d  = right_q;
    ovalid_d = ovalid_q & ~out_ready_i;
    res_d    = res_q;
    if (accept) begin
      if (last) begin
        col_d   = '0;
        run_d   = '0;
        lf_d    = 1'b0;
        left_d  = '0;
        right_d = '0;
        ovalid_d          = 1'b1;
        res_d.left_pos    = left_n;
        res_d.right_pos   = right_n;
        res_d.center_pos  = sum[lbcs_pkg::PosW:1];
        res_d.found       = (left_n != '0) & (right_n != '0);
        res_d.row_out     = row_tag_i;
      end else begin
        col_d = col_p1[CW-1:0];
        run_d = (take_left | take_right) ? '0 : run_inc;
        if (take_left) begin
          lf_d   = 1'b1;
          left_d = lbcs_pkg::PosW'(col_q);
        end
        if (take_right) right_d = lbcs_pkg::PosW'(col_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      run_q    <= '0;
      lf_q     <= 1'b0;
      left_q   <= '0;
      right_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      run_q    <= run_d;
      lf_q     <= lf_d;
      left_q   <= left_d;
      right_q  <= right_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = ovalid_q;
  assign result_o    = res_q;

endmodule
`default_nettype wire

/* verif/tb_lane_border_center_scan.sv */
`timescale 1ns / 100ps
// Testbench for lane_border_center_scan: lane rows checked against a border-tracking predictor.
module tb_lane_border_center_scan;

  localparam int unsigned MaxWidth     = lbcs_pkg::MaxWidthDefault;
  localparam int unsigned PosW         = lbcs_pkg::PosW;
  localparam int unsigned RunW         = lbcs_pkg::RunW;
  localparam int unsigned WidthW       = lbcs_pkg::WidthW;
  localparam int          HoldCycles   = 300;
  localparam int          RandomPixels = 150;
  localparam int          RandomRows   = 3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [0] pixel_on, [12:1] row_tag, [15:13] zero
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [11:0] left_pos, [23:12] right_pos, [35:24] center_pos, [36] found,
  // [48:37] row_out, [55:49] zero
  logic [55:0] m_axis_tdata;

  lane_border_center_scan i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predictor copy of the configuration and row state
  logic [WidthW-1:0] cfg_width   = lbcs_pkg::WidthReset;
  logic [RunW-1:0]   cfg_min_run = lbcs_pkg::MinRunReset;
  int unsigned       col_cnt     = 0;
  logic [RunW-1:0]   run_len     = '0;
  logic              left_seen   = 1'b0;
  logic [PosW-1:0]   left_col    = '0;
  logic [PosW-1:0]   right_col   = '0;

  lbcs_pkg::result_t pending_rows[$];
  int      errors        = 0;
  int      pixels_sent   = 0;
  int      rows_expected = 0;
  bit      tx_idle_on    = 1'b1;
  bit      rx_idle_on    = 1'b1;
  int      hold_gen      = 0;
  int      hold_seen     = 0;
  int      hold_cnt      = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic int unsigned row_width();
    int unsigned w;
    w = cfg_width;
    if (w > MaxWidth) w = MaxWidth;
    if (w < 1) w = 1;
    return w;
  endfunction

  task automatic track_borders(input logic pix, input logic [PosW-1:0] tag);
    int unsigned       w;
    int unsigned       half;
    int unsigned       col;
    logic [PosW:0]     sum;
    lbcs_pkg::result_t row;
    w    = row_width();
    half = w / 2;
    col  = col_cnt;
    if (pix) begin
      if (run_len < lbcs_pkg::RunMax) run_len++;
    end else begin
      run_len = '0;
    end
    if (run_len > cfg_min_run) begin
      if (!left_seen && col < half) begin
        left_seen = 1'b1;
        left_col  = col[PosW-1:0];
        run_len   = '0;
      end else if (left_seen && col > half) begin
        right_col = col[PosW-1:0];
        run_len   = '0;
      end
    end
    if (col + 1 >= w) begin
      sum            = {1'b0, left_col} + {1'b0, right_col};
      row.left_pos   = left_col;
      row.right_pos  = right_col;
      row.center_pos = sum[PosW:1];
      row.found      = (left_col != '0) && (right_col != '0);
      row.row_out    = tag;
      pending_rows.push_back(row);
      rows_expected++;
      col_cnt   = 0;
      run_len   = '0;
      left_seen = 1'b0;
      left_col  = '0;
      right_col = '0;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  // receiver: random stalls plus long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_cnt  = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 34);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_rows
    lbcs_pkg::result_t got;
    lbcs_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = lbcs_pkg::result_t'(m_axis_tdata[48:0]);
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row result: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        check_field("left_pos", want.left_pos, got.left_pos);
        check_field("right_pos", want.right_pos, got.right_pos);
        check_field("center_pos", want.center_pos, got.center_pos);
        check_field("found", want.found, got.found);
        check_field("row_out", want.row_out, got.row_out);
      end
    end
  end

  task automatic send_pixel(input logic pix, input logic [PosW-1:0] tag);
    int gap;
    gap = 0;
    if (tx_idle_on) while ($urandom_range(99) < 34) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, tag, pix};
    do @(posedge clk_i); while (!s_axis_tready);
    track_borders(pix, tag);
    pixels_sent++;
  endtask

  task automatic drain_rows();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] junk;
    drain_rows();
    junk = $urandom;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (idx == lbcs_pkg::RegImageWidth) ? {junk[31:WidthW], value[WidthW-1:0]}
                                                : {junk[31:RunW], value[RunW-1:0]};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == lbcs_pkg::RegImageWidth) cfg_width = value[WidthW-1:0];
    else cfg_min_run = value[RunW-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // pixel i of the row is bits[i]
  task automatic send_pattern(input logic [63:0] bits, input int n, input logic [PosW-1:0] tag);
    for (int i = 0; i < n; i++) send_pixel(bits[i], tag);
  endtask

  // finishes the current row: sparse or dense noise plus a few solid segments
  task automatic send_lane_row(input logic [PosW-1:0] tag, input bit tag_per_pixel);
    int unsigned w;
    int unsigned n;
    int unsigned noise;
    int unsigned start;
    int unsigned len;
    bit          line[];
    w = row_width();
    n = (col_cnt + 1 >= w) ? 1 : w - col_cnt;
    line = new[n];
    noise = ($urandom_range(9) < 2) ? 50 : $urandom_range(0, 10);
    foreach (line[i]) line[i] = ($urandom_range(99) < noise);
    repeat ($urandom_range(0, 3)) begin
      start = $urandom_range(0, n - 1);
      len   = $urandom_range(1, 20);
      for (int unsigned i = start; i < start + len && i < n; i++) line[i] = 1'b1;
    end
    foreach (line[i]) send_pixel(line[i], tag_per_pixel ? PosW'($urandom) : tag);
  endtask

  task automatic test_reset_settings();
    send_lane_row(PosW'($urandom), 1'b0);
  endtask

  task automatic test_short_rows();
    write_reg(lbcs_pkg::RegMinRun, 0);
    write_reg(lbcs_pkg::RegImageWidth, 4);
    send_pattern(64'b1010, 4, 12'hFFF);
    // border at column zero counts as none
    send_pattern(64'b1001, 4, 12'h000);
    // run over threshold at the half column keeps counting
    send_pattern(64'b1110, 4, 12'h555);
    // effective width of one: every pixel ends a row
    write_reg(lbcs_pkg::RegImageWidth, 0);
    send_pattern(64'b01, 2, 12'hAAA);
    write_reg(lbcs_pkg::RegImageWidth, 16);
    send_pattern(64'b111111, 6, 12'h123);
    // shrink the row while past the new last column
    write_reg(lbcs_pkg::RegImageWidth, 4);
    send_pattern(64'b1, 1, 12'h321);
  endtask

  task automatic test_min_run_extremes();
    write_reg(lbcs_pkg::RegImageWidth, 24);
    write_reg(lbcs_pkg::RegMinRun, 15);
    send_pattern({64{1'b1}}, 24, PosW'($urandom));
    send_lane_row(PosW'($urandom), 1'b0);
    write_reg(lbcs_pkg::RegMinRun, 14);
    send_pattern({64{1'b1}}, 24, PosW'($urandom));
    send_lane_row(PosW'($urandom), 1'b0);
    write_reg(lbcs_pkg::RegMinRun, 1);
    send_lane_row(PosW'($urandom), 1'b0);
    send_lane_row(PosW'($urandom), 1'b0);
  endtask

  // rows at and above the widest setting, closed early by shrinking the width
  task automatic test_widest_rows();
    write_reg(lbcs_pkg::RegMinRun, $urandom_range(1, 6));
    write_reg(lbcs_pkg::RegImageWidth, MaxWidth);
    send_pattern(64'h0000_00FF_00FF_0F00, 40, PosW'($urandom));
    write_reg(lbcs_pkg::RegImageWidth, 16);
    send_pattern(64'b1, 1, PosW'($urandom));
    write_reg(lbcs_pkg::RegImageWidth, 13'h1FFF);
    send_pattern(64'h0000_00F0_F0F0_FF00, 40, PosW'($urandom));
    write_reg(lbcs_pkg::RegImageWidth, 16);
    send_pattern(64'b1, 1, PosW'($urandom));
  endtask

  task automatic test_backpressure();
    write_reg(lbcs_pkg::RegImageWidth, 16);
    write_reg(lbcs_pkg::RegMinRun, 2);
    tx_idle_on = 1'b0;
    hold_gen++;
    repeat (6) send_lane_row(PosW'($urandom), 1'b0);
    tx_idle_on = 1'b1;
    drain_rows();
    repeat (2) send_lane_row(PosW'($urandom), 1'b0);
  endtask

  task automatic test_steady_stream();
    write_reg(lbcs_pkg::RegImageWidth, 24);
    write_reg(lbcs_pkg::RegMinRun, 3);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (5) send_lane_row(PosW'($urandom), 1'b0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random();
    int p0;
    int r0;
    int pick;
    p0 = pixels_sent;
    r0 = rows_expected;
    while (pixels_sent - p0 < RandomPixels || rows_expected - r0 < RandomRows) begin
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 30))
        send_pixel(1'($urandom_range(1)), PosW'($urandom));
      pick = $urandom_range(99);
      if (pick < 8) write_reg(lbcs_pkg::RegImageWidth, $urandom_range(0, 15));
      else if (pick < 90) write_reg(lbcs_pkg::RegImageWidth, $urandom_range(16, 48));
      else write_reg(lbcs_pkg::RegImageWidth, $urandom_range(49, 120));
      pick = $urandom_range(99);
      if (pick < 10) write_reg(lbcs_pkg::RegMinRun, 0);
      else if (pick < 20) write_reg(lbcs_pkg::RegMinRun, 15);
      else write_reg(lbcs_pkg::RegMinRun, $urandom_range(1, 14));
      repeat ($urandom_range(2, 6))
        send_lane_row(PosW'($urandom), $urandom_range(9) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_settings();
    test_short_rows();
    test_min_run_extremes();
    test_widest_rows();
    test_backpressure();
    test_steady_stream();
    test_random();
    drain_rows();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d row results still expected", $time, pending_rows.size());
    $display("Verification failed");
    $finish;
  end

endmodule
